// ===== rtl/cvp_pkg.sv =====
// Shared types and constants of the code point value parser.
`timescale 1ns / 1ps

package cvp_pkg;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_AMP     = 3'd1,
		PH_NUMSTRT = 3'd2,
		PH_DIGITS  = 3'd3,
		PH_SEMI    = 3'd4,
		PH_UTF     = 3'd5,
		PH_OK      = 3'd6,
		PH_ERR     = 3'd7
	} phase_t;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
	localparam logic [CP_W-1:0] MIN_2B   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_3B   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4B   = 21'h010000;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_F_LO   = 8'h66;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_F_UP   = 8'h46;

	localparam logic [7:0] MASK_C0   = 8'hC0;
	localparam logic [7:0] MASK_E0   = 8'hE0;
	localparam logic [7:0] MASK_F0   = 8'hF0;
	localparam logic [7:0] MASK_F8   = 8'hF8;
	localparam logic [7:0] LEAD_2B   = 8'hC0;
	localparam logic [7:0] LEAD_3B   = 8'hE0;
	localparam logic [7:0] LEAD_4B   = 8'hF0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Result item: code point in the low bits, valid flag above it.
	typedef struct packed {
		logic [1:0]      pad;
		logic            valid_res;
		logic [CP_W-1:0] code_point;
	} result_t;

endpackage

// ===== rtl/codepoint_value_parser_core.sv =====
// Top level of the code point value parser: byte-serial decoder with a two-entry result buffer.
`timescale 1ns / 1ps

// The block takes one byte of an attribute value per clock cycle, with no gaps needed between
// bytes or between values. A zero byte ends the value and registers one result item into the
// result buffer: the code point decoded from a numeric character reference or from the first
// UTF-8 character, and a flag that is 1 on success. Other bytes produce no result. The parse
// state is updated in the cycle a byte is accepted, so the sustained rate is one byte per cycle
// while the output drains. A two-entry result buffer lets the input keep flowing while a result
// waits on the output; s_axis_tready drops only when both entries are full.
module codepoint_value_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] value_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [20:0] code_point, [21] valid_res, [23:22] zero
);

	cvp_pkg::phase_t phase_q, phase_d;
	logic [cvp_pkg::CP_W-1:0] acc_q, acc_d;
	logic too_big_q, too_big_d;
	logic hex_q, hex_d;
	logic saw_q, saw_d;
	logic [1:0] left_q, left_d;
	logic [1:0] len_q, len_d;

	logic in_acc, is_term;
	logic [7:0] b;
	logic is_dec, is_hex_lo, is_hex_up, is_digit;
	logic [3:0] dval;
	logic use_hex;
	logic [25:0] mul10, mul16, nxt;
	logic [1:0] left_dec;

	cvp_pkg::result_t res_new;
	cvp_pkg::result_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic pop;

	assign b       = s_axis_tdata;
	assign in_acc  = s_axis_tvalid & s_axis_tready;
	assign is_term = (b == cvp_pkg::CH_NUL);
	assign pop     = m_axis_tvalid & m_axis_tready;

	assign s_axis_tready = ~skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// In the first byte after "&#" the base is still decimal unless that byte is x or X.
	assign use_hex   = hex_q & (phase_q == cvp_pkg::PH_DIGITS);
	assign is_dec    = (b >= cvp_pkg::CH_0) && (b <= cvp_pkg::CH_9);
	assign is_hex_lo = use_hex && (b >= cvp_pkg::CH_A_LO) && (b <= cvp_pkg::CH_F_LO);
	assign is_hex_up = use_hex && (b >= cvp_pkg::CH_A_UP) && (b <= cvp_pkg::CH_F_UP);
	assign is_digit  = is_dec | is_hex_lo | is_hex_up;

	always_comb begin
		dval = b[3:0];
		if (is_hex_lo || is_hex_up) begin
			dval = b[3:0] + 4'd9;
		end
	end

	assign mul16 = {1'b0, acc_q, 4'b0000};
	assign mul10 = {2'b00, acc_q, 3'b000} + {4'b0000, acc_q, 1'b0};
	assign nxt   = (use_hex ? mul16 : mul10) + {22'd0, dval};

	assign left_dec = left_q - 2'd1;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		too_big_d = too_big_q;
		hex_d     = hex_q;
		saw_d     = saw_q;
		left_d    = left_q;
		len_d     = len_q;
		if (is_term) begin
			phase_d   = cvp_pkg::PH_START;
			acc_d     = '0;
			too_big_d = 1'b0;
			hex_d     = 1'b0;
			saw_d     = 1'b0;
			left_d    = 2'd0;
			len_d     = 2'd0;
		end else begin
			case (phase_q)
				cvp_pkg::PH_START: begin
					if (b == cvp_pkg::CH_AMP) begin
						acc_d   = {13'd0, cvp_pkg::CH_AMP};
						phase_d = cvp_pkg::PH_AMP;
					end else if (!b[7]) begin
						acc_d   = {13'd0, b};
						phase_d = cvp_pkg::PH_OK;
					end else if ((b & cvp_pkg::MASK_E0) == cvp_pkg::LEAD_2B) begin
						acc_d   = {16'd0, b[4:0]};
						len_d   = 2'd1;
						left_d  = 2'd1;
						phase_d = cvp_pkg::PH_UTF;
					end else if ((b & cvp_pkg::MASK_F0) == cvp_pkg::LEAD_3B) begin
						acc_d   = {17'd0, b[3:0]};
						len_d   = 2'd2;
						left_d  = 2'd2;
						phase_d = cvp_pkg::PH_UTF;
					end else if ((b & cvp_pkg::MASK_F8) == cvp_pkg::LEAD_4B) begin
						acc_d   = {18'd0, b[2:0]};
						len_d   = 2'd3;
						left_d  = 2'd3;
						phase_d = cvp_pkg::PH_UTF;
					end else begin
						phase_d = cvp_pkg::PH_ERR;
					end
				end
				cvp_pkg::PH_AMP: begin
					if (b == cvp_pkg::CH_HASH) begin
						acc_d   = '0;
						phase_d = cvp_pkg::PH_NUMSTRT;
					end else begin
						phase_d = cvp_pkg::PH_OK;
					end
				end
				cvp_pkg::PH_NUMSTRT, cvp_pkg::PH_DIGITS: begin
					phase_d = cvp_pkg::PH_DIGITS;
					if ((phase_q == cvp_pkg::PH_NUMSTRT) &&
					    ((b == cvp_pkg::CH_X_LO) || (b == cvp_pkg::CH_X_UP))) begin
						hex_d = 1'b1;
					end else if (is_digit) begin
						saw_d = 1'b1;
						if (!too_big_q) begin
							if (nxt > {5'd0, cvp_pkg::MAX_CP}) begin
								too_big_d = 1'b1;
							end else begin
								acc_d = nxt[cvp_pkg::CP_W-1:0];
							end
						end
					end else if ((b == cvp_pkg::CH_SEMI) && saw_q) begin
						phase_d = cvp_pkg::PH_SEMI;
					end else begin
						phase_d = cvp_pkg::PH_ERR;
					end
				end
				cvp_pkg::PH_SEMI: begin
					phase_d = cvp_pkg::PH_ERR;
				end
				cvp_pkg::PH_UTF: begin
					if ((b & cvp_pkg::MASK_C0) != cvp_pkg::CONT_TAG) begin
						phase_d = cvp_pkg::PH_ERR;
					end else begin
						acc_d  = {acc_q[cvp_pkg::CP_W-7:0], b[5:0]};
						left_d = left_dec;
						if (left_dec == 2'd0) begin
							phase_d = cvp_pkg::PH_OK;
							case (len_q)
								2'd1: begin
									if (acc_d < cvp_pkg::MIN_2B) begin
										phase_d = cvp_pkg::PH_ERR;
									end
								end
								2'd2: begin
									if (acc_d < cvp_pkg::MIN_3B) begin
										phase_d = cvp_pkg::PH_ERR;
									end
								end
								default: begin
									if ((acc_d < cvp_pkg::MIN_4B) || (acc_d > cvp_pkg::MAX_CP)) begin
										phase_d = cvp_pkg::PH_ERR;
									end
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_new = '0;
		case (phase_q)
			cvp_pkg::PH_AMP, cvp_pkg::PH_OK: res_new.valid_res = 1'b1;
			cvp_pkg::PH_DIGITS:              res_new.valid_res = saw_q & ~too_big_q;
			cvp_pkg::PH_SEMI:                res_new.valid_res = ~too_big_q;
			default:                         res_new.valid_res = 1'b0;
		endcase
		if (res_new.valid_res) begin
			res_new.code_point = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cvp_pkg::PH_START;
			acc_q     <= '0;
			too_big_q <= 1'b0;
			hex_q     <= 1'b0;
			saw_q     <= 1'b0;
			left_q    <= 2'd0;
			len_q     <= 2'd0;
		end else if (in_acc) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			too_big_q <= too_big_d;
			hex_q     <= hex_d;
			saw_q     <= saw_d;
			left_q    <= left_d;
			len_q     <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc & is_term;
			end
		end else if (in_acc && is_term) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (in_acc && is_term) begin
			if (out_valid_q) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

endmodule
